/* rtl/ppbe_pkg.sv */
// Shared types, constants and arithmetic helpers for the piecewise basis evaluator.
// Depends on nothing; imported by every module of the block.

package ppbe_pkg;

  localparam int unsigned MaxModes = 5;
  localparam int unsigned MaxDofs  = 6;

  typedef logic signed [17:0] val_t;   // Q1.16 basis value
  typedef logic signed [18:0] fac_t;   // recurrence factor, up to two in magnitude
  typedef val_t [MaxModes-1:0] vec_t;  // mode values of the active segment

  localparam val_t OneQ16 = 18'sd65536;

  typedef enum logic [1:0] {
    BASIS_NONE     = 2'd0,
    BASIS_POWER    = 2'd1,
    BASIS_CHEB     = 2'd2,
    BASIS_LEGENDRE = 2'd3
  } basis_e;

  typedef enum logic [1:0] {
    REG_BASIS_MODE = 2'd0,
    REG_MODES      = 2'd1,
    REG_DOFS       = 2'd2,
    REG_NORM_RECIP = 2'd3
  } cfg_reg_e;

  // One evaluated position on its way to the emitter.
  typedef struct packed {
    logic seg;
    vec_t vals;
  } item_t;

  function automatic val_t clamp_unit(input logic signed [25:0] v);
    val_t r;
    if (v > 26'sd65536) begin
      r = OneQ16;
    end else if (v < -26'sd65536) begin
      r = -OneQ16;
    end else begin
      r = 18'(v);
    end
    return r;
  endfunction

  // One recurrence step: round(a * f / 2^16) - sub, clamped to the unit range.
  function automatic val_t mul_step(input val_t a, input fac_t f, input val_t sub);
    logic signed [36:0] p;
    logic signed [36:0] pr;
    logic signed [25:0] r;
    p  = 37'(a) * 37'(f);
    pr = p + 37'sd32768;
    r  = 26'(pr >>> 16) - 26'(sub);
    return clamp_unit(r);
  endfunction

endpackage

/* rtl/piecewise_polynomial_basis_eval.sv */
// Top level of the piecewise polynomial basis evaluator: registers and two units.
// Depends on ppbe_pkg, ppbe_basis and ppbe_emit.
//
//   channel  direction  handshake               payload
//   in       request    in_valid_i/in_ready_o   position_i
//   out      result     out_valid_o/out_ready_i dof_row_o, matrix_column_o,
//                                               basis_value_o, last_o
//   cfg      write      cfg_we_i                cfg_idx_i, cfg_data_i
//
// A request yields 2*M*D results (at most 60), one per cycle while out_ready_i is
// high; with M or D zero a request is taken every cycle.
// The evaluation pipeline has seven register stages, and the emitter loads the
// next request in the cycle its last result is taken, leaving no gap.
// Reset clears the pipeline valid bits and the emitter; a stall holds each full stage with no empty stage after it.

module piecewise_polynomial_basis_eval
  import ppbe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [23:0] position_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  dof_row_o,
  output logic [5:0]  matrix_column_o,
  output logic [17:0] basis_value_o,
  output logic        last_o
);

  basis_e      mode_q;
  logic [2:0]  modes_q;
  logic [2:0]  dofs_q;
  logic [31:0] norm_recip_q;

  logic [2:0] modes_sat, dofs_sat;
  logic       mid_valid, mid_ready;
  item_t      mid_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= BASIS_NONE;
      modes_q      <= '0;
      dofs_q       <= '0;
      norm_recip_q <= 32'h0001_0000;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_BASIS_MODE: mode_q       <= basis_e'(cfg_data_i[1:0]);
        REG_MODES:      modes_q      <= cfg_data_i[2:0];
        REG_DOFS:       dofs_q       <= cfg_data_i[2:0];
        REG_NORM_RECIP: norm_recip_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign modes_sat = (modes_q > 3'(MaxModes)) ? 3'(MaxModes) : modes_q;
  assign dofs_sat  = (dofs_q > 3'(MaxDofs)) ? 3'(MaxDofs) : dofs_q;

  ppbe_basis u_basis (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .position_i   (position_i),
    .norm_recip_i (norm_recip_q),
    .mode_i       (mode_q),
    .out_valid_o  (mid_valid),
    .out_ready_i  (mid_ready),
    .out_item_o   (mid_item)
  );

  ppbe_emit u_emit (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (mid_valid),
    .in_ready_o      (mid_ready),
    .in_item_i       (mid_item),
    .modes_i         (modes_sat),
    .dofs_i          (dofs_sat),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .dof_row_o       (dof_row_o),
    .matrix_column_o (matrix_column_o),
    .basis_value_o   (basis_value_o),
    .last_o          (last_o)
  );

endmodule

/* rtl/ppbe_basis.sv */
// Seven-stage pipeline from position to the mode values of the active segment.
// Depends on ppbe_pkg for the value types, basis codes and rounding helpers.

module ppbe_basis
  import ppbe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [23:0] position_i,
  input  logic [31:0] norm_recip_i,
  input  basis_e      mode_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output item_t       out_item_o
);

  localparam int unsigned Stages = 7;

  typedef struct packed {
    logic seg;
    val_t x;
    fac_t f;
    val_t y1;
    val_t y2;
    val_t y3;
    val_t y4;
  } chain_t;

  logic [Stages-1:0] vld_q;
  logic [Stages-1:0] en;

  logic [55:0] prod_q, prod_d;
  logic [32:0] t_q, t_d;
  logic        seg2_q, seg2_d;
  chain_t      c3_q, c3_d, c4_q, c4_d, c5_q, c5_d, c6_q, c6_d;
  item_t       item_q, item_d;

  logic cheb;
  assign cheb = (mode_i == BASIS_CHEB);

  // A stage moves when it is empty or its successor moves.
  always_comb begin
    en[Stages-1] = !vld_q[Stages-1] || out_ready_i;
    for (int k = Stages - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[Stages-1];
  assign out_item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < Stages; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // Stage 1: exact product position * reciprocal length, Q.32.
  assign prod_d = 56'(position_i) * 56'(norm_recip_i);

  // Stage 2: saturate to one, pick the half segment and map to t in Q.32.
  always_comb begin
    logic [32:0] s;
    logic [33:0] tw;
    s  = (prod_q > 56'h1_0000_0000) ? 33'h1_0000_0000 : prod_q[32:0];
    tw = {s, 1'b0} - 34'h1_0000_0000;
    if (s < 33'h0_8000_0000) begin
      t_d    = {s[31:0], 1'b0};
      seg2_d = 1'b0;
    end else if (s == 33'h0_8000_0000) begin
      // Exactly one half belongs to the first segment at its origin.
      t_d    = '0;
      seg2_d = 1'b0;
    end else begin
      t_d    = tw[32:0];
      seg2_d = 1'b1;
    end
  end

  // Stage 3: round to U in Q16, form X = 2U - 1 and the recurrence operands.
  always_comb begin
    logic [33:0]        tsum;
    logic [16:0]        u;
    logic signed [18:0] x19;
    val_t               x;
    tsum = 34'(t_q) + 34'd32768;
    u    = tsum[32:16];
    x19  = $signed({1'b0, u, 1'b0}) - 19'sd65536;
    x    = 18'(x19);
    c3_d     = '0;
    c3_d.seg = seg2_q;
    c3_d.x   = x;
    case (mode_i)
      BASIS_POWER: begin
        c3_d.f  = $signed({2'b00, u});
        c3_d.y1 = $signed({1'b0, u});
      end
      BASIS_CHEB: begin
        c3_d.f  = $signed({x, 1'b0});
        c3_d.y1 = x;
      end
      default: begin
        c3_d.f  = 19'(x);
        c3_d.y1 = x;
      end
    endcase
  end

  // Stages 4 to 6: one multiply each. Chebyshev subtracts the term two back.
  always_comb begin
    c4_d    = c3_q;
    c4_d.y2 = mul_step(c3_q.y1, c3_q.f, cheb ? OneQ16 : '0);
    c5_d    = c4_q;
    c5_d.y3 = mul_step(c4_q.y2, c4_q.f, cheb ? c4_q.y1 : '0);
    c6_d    = c5_q;
    c6_d.y4 = mul_step(c5_q.y3, c5_q.f, cheb ? c5_q.y2 : '0);
  end

  // Stage 7: Legendre combinations from the powers of X, and mode selection.
  always_comb begin
    logic signed [25:0] l2, l3, l4;
    l2 = (26'sd3 * 26'(c6_q.y2) - 26'sd65535) >>> 1;
    l3 = (26'sd5 * 26'(c6_q.y3) - 26'sd3 * 26'(c6_q.x) + 26'sd1) >>> 1;
    l4 = (26'sd35 * 26'(c6_q.y4) - 26'sd30 * 26'(c6_q.y2) + 26'sd196612) >>> 3;
    item_d.seg = c6_q.seg;
    case (mode_i)
      BASIS_POWER, BASIS_CHEB: begin
        item_d.vals = {c6_q.y4, c6_q.y3, c6_q.y2, c6_q.y1, OneQ16};
      end
      BASIS_LEGENDRE: begin
        item_d.vals = {clamp_unit(l4), clamp_unit(l3), clamp_unit(l2), c6_q.x, OneQ16};
      end
      default: begin
        item_d.vals = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) prod_q <= prod_d;
    if (en[1]) begin
      t_q    <= t_d;
      seg2_q <= seg2_d;
    end
    if (en[2]) c3_q   <= c3_d;
    if (en[3]) c4_q   <= c4_d;
    if (en[4]) c5_q   <= c5_d;
    if (en[5]) c6_q   <= c6_d;
    if (en[6]) item_q <= item_d;
  end

endmodule

/* rtl/ppbe_emit.sv */
// Walks one evaluated position over the rows and columns of the shape-matrix band.
// Depends on ppbe_pkg for the item and value types.

module ppbe_emit
  import ppbe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  item_t       in_item_i,
  input  logic [2:0]  modes_i,
  input  logic [2:0]  dofs_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  dof_row_o,
  output logic [5:0]  matrix_column_o,
  output logic [17:0] basis_value_o,
  output logic        last_o
);

  logic        busy_q, busy_d;
  item_t       item_q, item_d;
  logic [2:0]  d_q, d_d;
  logic        k_q, k_d;
  logic [2:0]  r_q, r_d;
  logic [5:0]  col_q, col_d;
  val_t        value_q, value_d;
  logic        last_q, last_d;

  logic       take, empty, r_wrap;
  logic [2:0] m_last, d_last;

  assign take       = in_valid_i && in_ready_o;
  assign in_ready_o = !busy_q || (out_ready_i && last_q);
  assign empty      = (modes_i == 3'd0) || (dofs_i == 3'd0);
  assign m_last     = modes_i - 3'd1;
  assign d_last     = dofs_i - 3'd1;
  assign r_wrap     = (r_q == m_last);

  always_comb begin
    busy_d  = busy_q;
    item_d  = item_q;
    d_d     = d_q;
    k_d     = k_q;
    r_d     = r_q;
    col_d   = col_q;
    value_d = value_q;
    last_d  = last_q;
    if (take) begin
      // A request for an empty matrix is taken and produces nothing.
      busy_d  = !empty;
      item_d  = in_item_i;
      d_d     = '0;
      k_d     = 1'b0;
      r_d     = '0;
      col_d   = '0;
      value_d = in_item_i.seg ? '0 : val_t'(in_item_i.vals[0]);
      last_d  = 1'b0;
    end else if (busy_q && out_ready_i && !last_q) begin
      r_d     = r_wrap ? 3'd0 : r_q + 3'd1;
      k_d     = r_wrap ? ~k_q : k_q;
      d_d     = (r_wrap && k_q) ? d_q + 3'd1 : d_q;
      col_d   = col_q + 6'd1;
      value_d = (k_d == item_q.seg) ? val_t'(item_q.vals[r_d]) : '0;
      last_d  = (d_d == d_last) && k_d && (r_d == m_last);
    end else if (busy_q && out_ready_i) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    d_q     <= d_d;
    k_q     <= k_d;
    r_q     <= r_d;
    col_q   <= col_d;
    value_q <= value_d;
    last_q  <= last_d;
  end

  assign out_valid_o     = busy_q;
  assign dof_row_o       = d_q;
  assign matrix_column_o = col_q;
  assign basis_value_o   = value_q;
  assign last_o          = last_q;

endmodule

/* test/ppbe_band_checker.sv */
`timescale 1ns / 100ps
// Band checker for the piecewise polynomial basis evaluator: follows register writes,
// predicts the shape-matrix band of every accepted position and compares the results.
// Depends on ppbe_pkg for the basis and register codes.

module ppbe_band_checker
  import ppbe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [23:0] position_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [2:0]  dof_row_i,
  input  logic [5:0]  matrix_column_i,
  input  logic [17:0] basis_value_i,
  input  logic        last_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam longint One = 65536;

  typedef struct packed {
    logic [2:0]         row;
    logic [5:0]         column;
    logic signed [17:0] value;
    logic               last;
  } band_entry_t;

  basis_e      basis_r;
  logic [2:0]  modes_r;
  logic [2:0]  dofs_r;
  logic [31:0] recip_r;
  band_entry_t band_entries[$];
  band_entry_t head;
  int unsigned fails;

  // floor(v / 2^k + 1/2)
  function automatic longint rshift_round(input longint v, input int k);
    return (v + (longint'(1) <<< (k - 1))) >>> k;
  endfunction

  function automatic longint unit_clamp(input longint v);
    if (v > One) return One;
    if (v < -One) return -One;
    return v;
  endfunction

  function automatic void eval_band(input logic [23:0] pos);
    longint unsigned s;
    longint unsigned t;
    longint u, x, p, prev, cur, nxt, x2, x3, x4;
    longint vals[MaxModes];
    longint leg[5];
    int unsigned m, dofs, total;
    bit seg;
    band_entry_t e;
    m = (modes_r > MaxModes) ? MaxModes : modes_r;
    dofs = (dofs_r > MaxDofs) ? MaxDofs : dofs_r;
    total = 2 * m;
    s = 64'(pos) * 64'(recip_r);
    if (s > 64'h1_0000_0000) s = 64'h1_0000_0000;
    seg = 1'b0;
    // The exact half point folds back to the start of the first segment.
    if (s < 64'h8000_0000) begin
      t = 2 * s;
    end else if (s == 64'h8000_0000) begin
      t = 0;
    end else begin
      t = 2 * s - 64'h1_0000_0000;
      seg = 1'b1;
    end
    u = longint'((t + 64'h8000) >> 16);
    x = 2 * u - One;
    foreach (vals[i]) vals[i] = 0;
    case (basis_r)
      BASIS_POWER: begin
        p = One;
        for (int i = 0; i < m; i++) begin
          vals[i] = p;
          p = unit_clamp(rshift_round(p * u, 16));
        end
      end
      BASIS_CHEB: begin
        prev = One;
        cur = x;
        for (int i = 0; i < m; i++) begin
          if (i == 0) begin
            vals[i] = One;
          end else if (i == 1) begin
            vals[i] = unit_clamp(x);
          end else begin
            nxt = unit_clamp(rshift_round(2 * x * cur, 16) - prev);
            prev = cur;
            cur = nxt;
            vals[i] = nxt;
          end
        end
      end
      BASIS_LEGENDRE: begin
        x2 = rshift_round(x * x, 16);
        x3 = rshift_round(x2 * x, 16);
        x4 = rshift_round(x3 * x, 16);
        leg[0] = One;
        leg[1] = x;
        leg[2] = rshift_round(3 * x2 - One, 1);
        leg[3] = rshift_round(5 * x3 - 3 * x, 1);
        leg[4] = rshift_round(35 * x4 - 30 * x2 + 3 * One, 3);
        for (int i = 0; i < m; i++) vals[i] = unit_clamp(leg[i]);
      end
      default: ;
    endcase
    for (int unsigned d = 0; d < dofs; d++) begin
      for (int unsigned j = 0; j < total; j++) begin
        e.row = 3'(d);
        e.column = 6'(d * total + j);
        e.value = 18'(((j / m) == seg) ? vals[j % m] : 0);
        e.last = (d + 1 == dofs) && (j + 1 == total);
        band_entries.push_back(e);
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      basis_r = BASIS_NONE;
      modes_r = '0;
      dofs_r = '0;
      recip_r = 32'd65536;
      fails = 0;
      band_entries.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (band_entries.size() == 0) begin
          fails++;
          $display("%0t: unexpected result row %0d column %0d value %0d last %0b", $time,
                   dof_row_i, matrix_column_i, $signed(basis_value_i), last_i);
        end else begin
          head = band_entries.pop_front();
          if ({dof_row_i, matrix_column_i, basis_value_i, last_i} != head) begin
            fails++;
            $display("%0t: mismatch expected row %0d column %0d value %0d last %0b", $time,
                     head.row, head.column, head.value, head.last);
            $display("%0t:          actual row %0d column %0d value %0d last %0b", $time,
                     dof_row_i, matrix_column_i, $signed(basis_value_i), last_i);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_BASIS_MODE: basis_r = basis_e'(cfg_data_i[1:0]);
          REG_MODES:      modes_r = cfg_data_i[2:0];
          REG_DOFS:       dofs_r = cfg_data_i[2:0];
          REG_NORM_RECIP: recip_r = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) eval_band(position_i);
      fail_count_o <= fails;
      pending_o <= band_entries.size();
    end
  end

endmodule

/* test/piecewise_polynomial_basis_eval_test.sv */
`timescale 1ns / 100ps
// Testbench top for piecewise_polynomial_basis_eval: drives reset, register writes,
// position requests and output stalls; depends on ppbe_pkg and ppbe_band_checker.

module piecewise_polynomial_basis_eval_test;
  import ppbe_pkg::*;

  localparam int unsigned IdleLimit    = 2000;
  localparam int unsigned LongHold     = 400;
  localparam int unsigned Settle       = 16;
  localparam int unsigned RandomPhases = 9;
  localparam int unsigned PhaseItems   = 45;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = REG_BASIS_MODE;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [23:0] position_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  dof_row_o;
  logic [5:0]  matrix_column_o;
  logic [17:0] basis_value_o;
  logic        last_o;

  int unsigned fail_count;
  int unsigned pending;
  logic        calm = 1'b0;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned ready_gap = 0;
  int unsigned idle_cycles = 0;

  piecewise_polynomial_basis_eval u_top (.*);

  ppbe_band_checker u_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .position_i      (position_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .dof_row_i       (dof_row_o),
    .matrix_column_i (matrix_column_o),
    .basis_value_i   (basis_value_o),
    .last_i          (last_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Result side: random stall bursts, plus one long hold-off that backs up the block.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      ready_gap <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= LongHold - 1;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (ready_gap != 0) begin
      ready_gap <= ready_gap - 1;
      out_ready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      ready_gap <= $urandom_range(0, 18);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Mostly spread over s in [0, 2), now and then on the segment boundary or fully random.
  function automatic logic [23:0] pick_position(input logic [31:0] recip);
    longint unsigned span;
    longint unsigned half_pos;
    if (recip == 0 || $urandom_range(0, 7) == 0) return 24'($urandom);
    half_pos = (64'd1 << 31) / recip;
    span = half_pos * 4;
    if (span > 64'hFF_FFFF) span = 64'hFF_FFFF;
    if (half_pos <= span && $urandom_range(0, 15) == 0) return 24'(half_pos);
    return 24'($urandom_range(0, 32'(span)));
  endfunction

  // Waits until every predicted result has arrived, then lets the pipeline drain of
  // requests that produce no results.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  task automatic load_config(input basis_e mode, input int unsigned modes,
                             input int unsigned dofs, input logic [31:0] recip,
                             input bit with_recip);
    settle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_BASIS_MODE;
    cfg_data_i <= {30'($urandom), mode};
    @(posedge clk_i);
    cfg_idx_i <= REG_MODES;
    cfg_data_i <= {29'($urandom), 3'(modes)};
    @(posedge clk_i);
    cfg_idx_i <= REG_DOFS;
    cfg_data_i <= {29'($urandom), 3'(dofs)};
    @(posedge clk_i);
    if (with_recip) begin
      cfg_idx_i <= REG_NORM_RECIP;
      cfg_data_i <= recip;
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_position(input logic [23:0] pos);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    position_i <= pos;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] recip;
    basis_e mode;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values give an empty matrix.
    send_position(24'h123456);

    // The length register keeps its reset value of one, so 0x8000 is the exact half.
    load_config(BASIS_POWER, 5, 1, 32'h0, 1'b0);
    send_position(24'h000000);
    send_position(24'h007FFF);
    send_position(24'h008000);
    send_position(24'h008001);
    send_position(24'h010000);
    send_position(24'hFFFFFF);

    load_config(BASIS_CHEB, 5, 2, 32'h0001_0000, 1'b1);
    send_position(24'h004000);
    send_position(24'h002000);
    send_position(24'h00C000);
    send_position(24'h010000);

    load_config(BASIS_LEGENDRE, 5, 1, 32'h0001_0000, 1'b1);
    send_position(24'h000000);
    send_position(24'h003000);
    send_position(24'h00A000);
    send_position(24'h010000);

    load_config(BASIS_NONE, 2, 3, 32'hFFFF_FFFF, 1'b1);
    send_position(24'h000001);
    send_position(24'h000000);

    // Counts above the maximum saturate to the full sixty-entry band.
    load_config(BASIS_LEGENDRE, 7, 7, 32'h0001_8000, 1'b1);
    send_position(24'h005555);

    load_config(BASIS_POWER, 1, 6, 32'h0, 1'b1);
    send_position(24'hABCDEF);

    load_config(BASIS_CHEB, 3, 0, 32'h0002_0000, 1'b1);
    send_position(24'hFFFFFF);

    for (int ph = 0; ph < RandomPhases; ph++) begin
      recip = $urandom >> $urandom_range(4, 24);
      if (ph == 0) begin
        load_config(BASIS_CHEB, 5, 6, recip, 1'b1);
      end else begin
        mode = basis_e'($urandom_range(0, 3));
        load_config(mode, $urandom_range(0, 7), $urandom_range(0, 7), recip, 1'b1);
      end
      if (ph == RandomPhases - 1) calm <= 1'b1;
      for (int n = 0; n < PhaseItems; n++) begin
        if (ph == 0 && n == 4) hold_req <= 1'b1;
        send_position(pick_position(recip));
      end
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/ppbe_pkg.sv
rtl/ppbe_basis.sv
rtl/ppbe_emit.sv
rtl/piecewise_polynomial_basis_eval.sv
test/ppbe_band_checker.sv
test/piecewise_polynomial_basis_eval_test.sv
